// File: hdl/krt_pkg.sv
// Shared types, codes and constants for the keyed record table.
package krt_pkg;

   localparam int KRT_ENTRIES = 16;

   localparam logic [63:0] NULL_TEXT = 64'h0000_0000_4C4C_554E;

   localparam logic [2:0] MODE_INSERT = 3'd0;
   localparam logic [2:0] MODE_CHANGE = 3'd1;
   localparam logic [2:0] MODE_REMOVE = 3'd2;
   localparam logic [2:0] MODE_SEARCH = 3'd3;
   localparam logic [2:0] MODE_DUMP   = 3'd4;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_DUP  = 2'd2;
   localparam logic [1:0] ST_MISS = 2'd3;

   typedef struct packed {
      logic        [2:0]  mode;
      logic signed [31:0] key_code;
      logic        [63:0] name_part0;
      logic        [63:0] name_part1;
      logic        [31:0] name_part2;
      logic signed [31:0] population;
   } req_word_type;

   typedef struct packed {
      logic        [1:0]  status;
      logic        [3:0]  position;
      logic signed [31:0] out_code;
      logic        [63:0] out_name0;
      logic        [63:0] out_name1;
      logic        [31:0] out_name2;
      logic signed [31:0] out_population;
      logic               last;
   } rsp_word_type;

   typedef struct packed {
      logic [63:0] name0;
      logic [63:0] name1;
      logic [31:0] name2;
      logic [31:0] population;
   } record_type;

   typedef struct packed {
      logic capture;
      logic resolve;
      logic dump_read;
      logic dump_emit;
   } krt_cmd_type;

   typedef struct packed {
      logic dump_last;
   } krt_sts_type;

endpackage

// File: hdl/krt_ctrl.sv
// Sequencer for the keyed record table: handshakes, operation steps and dump walk.
module krt_ctrl
   import krt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic [2:0]  req_mode,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output krt_cmd_type cmd,
   input  krt_sts_type sts
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_RESOLVE,
      S_DUMP_READ,
      S_DUMP_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;
   logic      accept;

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      cmd.capture   = accept;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_mode == MODE_DUMP) begin
                  state_in = S_DUMP_READ;
               end else if (req_mode == MODE_INSERT || req_mode == MODE_CHANGE ||
                            req_mode == MODE_REMOVE || req_mode == MODE_SEARCH) begin
                  state_in = S_RESOLVE;
               end
            end
         end
         S_RESOLVE: begin
            if (slot_free) begin
               cmd.resolve = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_DUMP_READ: begin
            cmd.dump_read = 1'b1;
            state_in      = S_DUMP_EMIT;
         end
         S_DUMP_EMIT: begin
            if (slot_free) begin
               cmd.dump_emit = 1'b1;
               state_in      = sts.dump_last ? S_IDLE : S_DUMP_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = (cmd.resolve || cmd.dump_emit) ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/krt_dpath.sv
// Datapath for the keyed record table: key registers, record memory and result register.
module krt_dpath
   import krt_pkg::*;
#(
   parameter int TABLE_ENTRIES = KRT_ENTRIES
)
(
   input  logic         clock,
   input  logic         reset,
   input  req_word_type req_word,
   output rsp_word_type rsp_word,
   input  krt_cmd_type  cmd,
   output krt_sts_type  sts
);

   localparam int IDX_W = $clog2(TABLE_ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   logic signed [31:0]     key_ff [TABLE_ENTRIES];
   logic [TABLE_ENTRIES-1:0] valid_ff;
   record_type             mem [TABLE_ENTRIES];

   req_word_type           item_ff;
   logic [TABLE_ENTRIES-1:0] hit_vec_ff, empty_vec_ff;
   logic [IDX_W-1:0]       cnt_ff;
   record_type             rd_ff;
   logic                   rd_valid_ff;
   logic signed [31:0]     rd_key_ff;
   rsp_word_type           rsp_ff, rsp_in;

   logic                   hit_any, empty_any;
   logic [IDX_W-1:0]       hit_idx, empty_idx;
   logic                   key_we, valid_we, mem_we, valid_wdata;
   logic signed [31:0]     key_wdata;
   logic [IDX_W-1:0]       wr_idx;
   record_type             wr_data;

   assign sts.dump_last = (cnt_ff == LAST_IDX);
   assign rsp_word      = rsp_ff;

   // first hit and first empty slot, lowest index wins
   always_comb begin
      hit_any   = 1'b0;
      empty_any = 1'b0;
      hit_idx   = '0;
      empty_idx = '0;
      for (int i = TABLE_ENTRIES - 1; i >= 0; i--) begin
         if (hit_vec_ff[i]) begin
            hit_any = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (empty_vec_ff[i]) begin
            empty_any = 1'b1;
            empty_idx = IDX_W'(i);
         end
      end
   end

   always_comb begin
      key_we         = 1'b0;
      valid_we       = 1'b0;
      mem_we         = 1'b0;
      valid_wdata    = 1'b0;
      key_wdata      = item_ff.key_code;
      wr_idx         = hit_idx;
      wr_data.name0      = item_ff.name_part0;
      wr_data.name1      = item_ff.name_part1;
      wr_data.name2      = item_ff.name_part2;
      wr_data.population = item_ff.population;
      rsp_in         = '0;
      rsp_in.status  = ST_OK;
      rsp_in.last    = 1'b1;
      if (cmd.dump_emit) begin
         rsp_in.position       = 4'(cnt_ff);
         rsp_in.out_code       = rd_key_ff;
         rsp_in.out_name0      = rd_valid_ff ? rd_ff.name0 : NULL_TEXT;
         rsp_in.out_name1      = rd_valid_ff ? rd_ff.name1 : '0;
         rsp_in.out_name2      = rd_valid_ff ? rd_ff.name2 : '0;
         rsp_in.out_population = rd_valid_ff ? rd_ff.population : '0;
         rsp_in.last           = sts.dump_last;
      end else begin
         case (item_ff.mode)
            MODE_INSERT: begin
               if (hit_any) begin
                  rsp_in.status   = ST_DUP;
                  rsp_in.position = 4'(hit_idx);
               end else if (!empty_any) begin
                  rsp_in.status = ST_FULL;
               end else begin
                  rsp_in.position = 4'(empty_idx);
                  wr_idx          = empty_idx;
                  key_we          = cmd.resolve;
                  mem_we          = cmd.resolve;
                  valid_we        = cmd.resolve;
                  valid_wdata     = 1'b1;
               end
            end
            MODE_CHANGE: begin
               if (hit_any) begin
                  rsp_in.position = 4'(hit_idx);
                  mem_we          = cmd.resolve;
                  valid_we        = cmd.resolve;
                  valid_wdata     = 1'b1;
               end else begin
                  rsp_in.status = ST_MISS;
               end
            end
            MODE_REMOVE: begin
               if (hit_any) begin
                  rsp_in.position = 4'(hit_idx);
                  key_we          = cmd.resolve;
                  key_wdata       = '0;
                  valid_we        = cmd.resolve;
                  valid_wdata     = 1'b0;
               end else begin
                  rsp_in.status = ST_MISS;
               end
            end
            MODE_SEARCH: begin
               if (hit_any) begin
                  rsp_in.position = 4'(hit_idx);
               end else begin
                  rsp_in.status = ST_MISS;
               end
            end
            default: begin
               rsp_in.status = ST_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            key_ff[i] <= '0;
         end
         valid_ff <= '0;
      end else begin
         if (key_we) begin
            key_ff[wr_idx] <= key_wdata;
         end
         if (valid_we) begin
            valid_ff[wr_idx] <= valid_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_idx] <= wr_data;
      end
      if (cmd.dump_read) begin
         rd_ff <= mem[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         item_ff <= req_word;
         cnt_ff  <= '0;
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            hit_vec_ff[i]   <= (key_ff[i] == req_word.key_code);
            empty_vec_ff[i] <= (key_ff[i] == 32'sd0);
         end
      end else if (cmd.dump_emit) begin
         cnt_ff <= cnt_ff + IDX_W'(1);
      end
      if (cmd.dump_read) begin
         rd_valid_ff <= valid_ff[cnt_ff];
         rd_key_ff   <= key_ff[cnt_ff];
      end
      if (cmd.resolve || cmd.dump_emit) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

// File: hdl/keyed_record_table_core.sv
// Top level of the keyed record table: sequencer plus datapath.
// Usage:
//   Request channel (req_valid, req_stall, req_word) takes one operation word:
//   insert, change, remove, search or dump. Response channel (rsp_valid,
//   rsp_stall, rsp_word) returns one word per operation, or one word per slot
//   for a dump with last set on the final slot. Undefined modes give no word.
// Operation steps:
//   For insert, change, remove and search the word is taken and all keys
//   are compared in parallel into hit and empty vectors, then the first hit
//   or empty slot is picked, the slot is written for a successful insert,
//   change or remove, and the response register is loaded. A dump walks the
//   record memory slot by slot (registered read, then response load).
//   A new request is taken as soon as the response register is loaded, while
//   that response still waits to be taken.
// Reset: all slots empty (code 0, name "NULL", population 0); per-slot valid
//   bits stand in for the record memory contents, so no clearing pass runs.
// Stall: a stalled response holds in the output register; the next result,
//   and with it any further request, waits until the register frees.
module keyed_record_table_core
   import krt_pkg::*;
#(
   parameter int TABLE_ENTRIES = KRT_ENTRIES
)
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   krt_cmd_type cmd;
   krt_sts_type sts;

   krt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_word.mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   krt_dpath #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_dpath (
      .clock    (clock),
      .reset    (reset),
      .req_word (req_word),
      .rsp_word (rsp_word),
      .cmd      (cmd),
      .sts      (sts)
   );

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      (cmd.resolve || cmd.dump_emit) |=> rsp_valid)
      else $error("response load did not raise rsp_valid");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |-> !(cmd.resolve || cmd.dump_emit || cmd.dump_read))
      else $error("request taken while an operation is in progress");

   a_dump_ends: assert property (@(posedge clock) disable iff (reset)
      (cmd.dump_emit && sts.dump_last) |=> !req_stall)
      else $error("block not idle after final dump word");

   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.resolve, cmd.dump_read, cmd.dump_emit}))
      else $error("more than one datapath command at once");

endmodule

// File: tb/sv/tb_keyed_record_table_core.sv
`timescale 1ns / 100ps
// Testbench for keyed_record_table_core: table operations checked against a local table model.
module tb_keyed_record_table_core;
   import krt_pkg::*;

   localparam int SLOTS = KRT_ENTRIES;
   localparam int POOL = 20;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;

   logic signed [31:0] slot_key [SLOTS];
   logic        [63:0] slot_name0 [SLOTS];
   logic        [63:0] slot_name1 [SLOTS];
   logic        [31:0] slot_name2 [SLOTS];
   logic signed [31:0] slot_pop [SLOTS];
   logic signed [31:0] key_pool [POOL];

   rsp_word_type pending_rsp [$];
   int           errors = 0;
   bit           send_idle = 1'b0;
   bit           recv_idle = 1'b0;
   int           stall_left = 0;

   keyed_record_table_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always #2 clock = ~clock;

   function automatic int idle_length();
      int r;
      r = $urandom_range(99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 8);
   endfunction

   function automatic void clear_record(int i);
      slot_key[i]   = '0;
      slot_name0[i] = NULL_TEXT;
      slot_name1[i] = '0;
      slot_name2[i] = '0;
      slot_pop[i]   = '0;
   endfunction

   function automatic void store_record(int i, req_word_type w);
      slot_name0[i] = w.name_part0;
      slot_name1[i] = w.name_part1;
      slot_name2[i] = w.name_part2;
      slot_pop[i]   = w.population;
   endfunction

   function automatic req_word_type make_word(logic [2:0] mode, logic signed [31:0] key,
                                              logic [63:0] n0, logic [63:0] n1,
                                              logic [31:0] n2, logic signed [31:0] pop);
      req_word_type w;
      w.mode       = mode;
      w.key_code   = key;
      w.name_part0 = n0;
      w.name_part1 = n1;
      w.name_part2 = n2;
      w.population = pop;
      return w;
   endfunction

   function automatic req_word_type random_word(logic [2:0] mode, logic signed [31:0] key);
      return make_word(mode, key, {$urandom, $urandom}, {$urandom, $urandom}, $urandom,
                       $urandom);
   endfunction

   function automatic void predict_table(req_word_type w);
      int           hit;
      int           empty;
      rsp_word_type r;
      hit   = -1;
      empty = -1;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (slot_key[i] == w.key_code) hit = i;
         if (slot_key[i] == 0) empty = i;
      end
      r      = '0;
      r.last = 1'b1;
      case (w.mode)
         MODE_INSERT: begin
            if (hit >= 0) begin
               r.status   = ST_DUP;
               r.position = 4'(hit);
            end else if (empty < 0) begin
               r.status = ST_FULL;
            end else begin
               slot_key[empty] = w.key_code;
               store_record(empty, w);
               r.status   = ST_OK;
               r.position = 4'(empty);
            end
            pending_rsp.push_back(r);
         end
         MODE_CHANGE, MODE_REMOVE, MODE_SEARCH: begin
            if (hit >= 0) begin
               if (w.mode == MODE_CHANGE) store_record(hit, w);
               if (w.mode == MODE_REMOVE) clear_record(hit);
               r.status   = ST_OK;
               r.position = 4'(hit);
            end else begin
               r.status = ST_MISS;
            end
            pending_rsp.push_back(r);
         end
         MODE_DUMP: begin
            for (int i = 0; i < SLOTS; i++) begin
               r.status         = ST_OK;
               r.position       = 4'(i);
               r.out_code       = slot_key[i];
               r.out_name0      = slot_name0[i];
               r.out_name1      = slot_name1[i];
               r.out_name2      = slot_name2[i];
               r.out_population = slot_pop[i];
               r.last           = (i == SLOTS - 1);
               pending_rsp.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic void check_field(string tag, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, tag, want, got);
         errors++;
      end
   endfunction

   always @(negedge clock) begin
      if (stall_left == 0 && recv_idle) stall_left = idle_length();
      if (stall_left > 0) begin
         stall_left = stall_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected word, expected none, actual %h", $time, rsp_word);
            errors++;
         end else begin
            want = pending_rsp.pop_front();
            check_field("status", 64'(want.status), 64'(rsp_word.status));
            check_field("position", 64'(want.position), 64'(rsp_word.position));
            check_field("out_code", 64'(want.out_code), 64'(rsp_word.out_code));
            check_field("out_name0", want.out_name0, rsp_word.out_name0);
            check_field("out_name1", want.out_name1, rsp_word.out_name1);
            check_field("out_name2", 64'(want.out_name2), 64'(rsp_word.out_name2));
            check_field("out_population", 64'(want.out_population),
                        64'(rsp_word.out_population));
            check_field("last", 64'(want.last), 64'(rsp_word.last));
         end
      end
   end

   task automatic send_word(input req_word_type w);
      int gap;
      @(negedge clock);
      req_valid <= 1'b1;
      req_word  <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_table(w);
      gap = send_idle ? idle_length() : 0;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic wait_for_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      send_word(random_word(MODE_DUMP, 32'sd0));
      send_word(random_word(MODE_SEARCH, 32'sd5));
      send_word(random_word(MODE_CHANGE, 32'sd5));
      send_word(random_word(MODE_REMOVE, 32'sd5));
      send_word(random_word(MODE_INSERT, 32'sd0));
      send_word(make_word(MODE_INSERT, 32'h7FFF_FFFF, '1, '1, '1, 32'h8000_0000));
      send_word(make_word(MODE_INSERT, 32'h8000_0000, '0, '0, '0, 32'h7FFF_FFFF));
      send_word(make_word(MODE_INSERT, -32'sd1, 64'h4847_4600_4443_4241,
                          64'h0000_0000_0000_4A49, 32'h4B00_0000, -32'sd1));
      send_word(random_word(MODE_INSERT, 32'h7FFF_FFFF));
      send_word(make_word(MODE_CHANGE, 32'sd0, 64'h0123_4567_89AB_CDEF,
                          64'hFEDC_BA98_7654_3210, 32'hA5A5_5A5A, 32'sd123));
      send_word(random_word(MODE_DUMP, 32'sd0));
      send_word(random_word(MODE_REMOVE, 32'sd0));
      send_word(random_word(MODE_CHANGE, 32'h8000_0000));
      send_word(random_word(MODE_SEARCH, -32'sd1));
      send_word(random_word(MODE_REMOVE, 32'h8000_0000));
      send_word(random_word(MODE_SEARCH, 32'h8000_0000));
      send_word(random_word(MODE_INSERT, 32'sd1));
      for (int k = 1; k <= 3; k++) send_word(random_word(MODE_DUMP + 3'(k), $urandom));
      send_word(random_word(MODE_DUMP, 32'sd0));
   endtask

   task automatic test_table_full();
      logic signed [31:0] held [SLOTS];
      bit                 has_room;
      has_room = 1'b1;
      while (has_room) begin
         send_word(random_word(MODE_INSERT, $urandom | 32'sd1));
         has_room = 1'b0;
         for (int i = 0; i < SLOTS; i++) if (slot_key[i] == 0) has_room = 1'b1;
      end
      send_word(random_word(MODE_INSERT, 32'sd2));
      send_word(random_word(MODE_INSERT, slot_key[SLOTS - 3]));
      send_word(random_word(MODE_INSERT, 32'sd0));
      send_word(random_word(MODE_CHANGE, 32'sd0));
      send_word(random_word(MODE_REMOVE, 32'sd0));
      send_word(random_word(MODE_SEARCH, 32'sd0));
      send_word(random_word(MODE_DUMP, 32'sd0));
      send_word(random_word(MODE_REMOVE, slot_key[5]));
      send_word(random_word(MODE_INSERT, 32'sd4));
      send_word(random_word(MODE_DUMP, 32'sd0));
      for (int i = 0; i < SLOTS; i++) held[i] = slot_key[i];
      for (int i = 0; i < SLOTS; i++) send_word(random_word(MODE_REMOVE, held[i]));
   endtask

   task automatic test_random(int words);
      int                 done;
      int                 pick;
      logic [2:0]         mode;
      logic signed [31:0] key;
      done = 0;
      while (done < words) begin
         pick = $urandom_range(99);
         if (pick < 30) mode = MODE_INSERT;
         else if (pick < 45) mode = MODE_CHANGE;
         else if (pick < 70) mode = MODE_REMOVE;
         else if (pick < 88) mode = MODE_SEARCH;
         else if (pick < 93) mode = MODE_DUMP;
         else mode = MODE_DUMP + 3'($urandom_range(3, 1));
         pick = $urandom_range(99);
         if (pick < 80) key = key_pool[$urandom_range(POOL - 1)];
         else if (pick < 88) key = '0;
         else key = $urandom;
         send_word(random_word(mode, key));
         if (mode <= MODE_DUMP) done++;
      end
   endtask

   initial begin
      for (int i = 0; i < SLOTS; i++) clear_record(i);
      key_pool[0] = 32'h7FFF_FFFF;
      key_pool[1] = 32'h8000_0000;
      key_pool[2] = -32'sd1;
      key_pool[3] = 32'sd1;
      for (int i = 4; i < POOL; i++) key_pool[i] = $urandom | 32'sd1;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle = 1'b1;
      recv_idle = 1'b1;
      test_directed();
      test_table_full();
      test_random(60);
      wait_for_responses();
      send_idle = 1'b0;
      recv_idle = 1'b0;
      test_random(40);
      send_idle = 1'b1;
      test_random(30);
      send_idle = 1'b0;
      recv_idle = 1'b1;
      test_random(30);

      recv_idle = 1'b0;
      wait_for_responses();
      repeat (40) @(posedge clock);
      if (errors == 0) begin
         $display("tb_keyed_record_table_core OK");
      end else begin
         $display("tb_keyed_record_table_core NOT OK");
      end
      $finish;
   end

   initial begin
      #3ms;
      $display("%0t: timeout", $time);
      $display("tb_keyed_record_table_core NOT OK");
      $finish;
   end

endmodule

// File: keyed_record_table_core.f
hdl/krt_pkg.sv
hdl/krt_ctrl.sv
hdl/krt_dpath.sv
hdl/keyed_record_table_core.sv
tb/sv/tb_keyed_record_table_core.sv
